// ----- rtl/bcb_pkg.sv -----
// ----------------------------------------------------------------------------
// bcb_pkg
// Shared constants for the bilinear coverage blend block.
// ----------------------------------------------------------------------------
package bcb_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int LUT_AW      = $clog2(TABLE_DEPTH);
  localparam int ALPHA_W     = 8;
  localparam int PIXEL_W     = 16;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COVERAGE_FLOOR = 1'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

endpackage

// ----- rtl/bcb_ram.sv -----
// ----------------------------------------------------------------------------
// bcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bilinear_coverage_blend_rgb565.sv -----
// ----------------------------------------------------------------------------
// bilinear_coverage_blend_rgb565
// Bilinear coverage sample, alpha table lookup, edge fade and RGB565 blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accepted edge:
//   op = 0 loads one alpha table entry, op = 1 blends one pixel. Every item
//   yields exactly one result on the output channel (out_valid / out_stall):
//   pixel_out and write_enable, in input order.
//   Configuration (cfg_write / cfg_index / cfg_data) sets fg_color and
//   coverage_floor; write it only while no item is in flight.
//   Six register stages: interpolation products, vertical product, coverage
//   and table read, fade product, fade divide, blend into the output register.
//   An accepted item moves through these stages to out_valid; the block takes
//   one item per cycle while out_stall is low, as the six-stage pipeline has no shared unit.
//   The alpha table is a 256 x 8 RAM read and written in the same stage, so a
//   load is seen by every later pixel.
//   Reset clears the pipeline, both registers and the table valid bits (an
//   entry never loaded reads as zero); no clearing pass is needed.
//   A stall on the output holds the result; bubbles inside the pipeline keep
//   filling, and in_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module bilinear_coverage_blend_rgb565 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [7:0]                     lut_index,
  input  logic [7:0]                     lut_value,
  input  logic [7:0]                     texel_00,
  input  logic [7:0]                     texel_10,
  input  logic [7:0]                     texel_01,
  input  logic [7:0]                     texel_11,
  input  logic [15:0]                    frac_x,
  input  logic [15:0]                    frac_y,
  input  logic [7:0]                     edge_alpha,
  input  logic [15:0]                    bg_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    pixel_out,
  output logic                           write_enable
);

  logic [15:0] fg_color;
  logic [7:0]  coverage_floor;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5, r6;

  // stage 1
  logic        op1;
  logic [7:0]  idx1, val1, edge1;
  logic [15:0] fy1, bg1;
  logic [23:0] lo1, hi1;
  // stage 2
  logic               op2;
  logic [7:0]         idx2, val2, edge2;
  logic [15:0]        bg2;
  logic [23:0]        lo2;
  logic signed [41:0] prod2;
  // stage 3
  logic        pass3, hit3;
  logic [7:0]  edge3, tab_rdata;
  logic [15:0] bg3;
  // stage 4
  logic        pass4;
  logic [7:0]  atab4, edge4;
  logic [15:0] bg4, mul4;
  // stage 5
  logic        we5;
  logic [7:0]  alpha5;
  logic [15:0] bg5;

  logic [bcb_pkg::TABLE_DEPTH-1:0] tab_valid;

  logic signed [8:0]  dx_lo, dx_hi;
  logic signed [25:0] px_lo, px_hi;
  logic [26:0]        lo_full, hi_full;
  logic signed [24:0] diff1;
  logic signed [41:0] prod_next;
  logic signed [25:0] v_sum;
  logic [7:0]         cov;
  logic               pass_next, tab_we;
  logic [7:0]         atab_next;
  logic [15:0]        mul_next, div_sum;
  logic [7:0]         alpha_next;
  logic [15:0]        bg_std, blend_std, pixel_next;
  logic [7:0]         inv;
  logic [20:0]        fg_rb, bg_rb;
  logic [10:0]        fg_g, bg_g;
  logic [29:0]        sum_rb;
  logic [19:0]        sum_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color       <= '0;
      coverage_floor <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcb_pkg::CFG_FG_COLOR:       fg_color       <= cfg_data;
        bcb_pkg::CFG_COVERAGE_FLOOR: coverage_floor <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign r6       = !out_valid || !out_stall;
  assign r5       = !v5 || r6;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_stall = !r1;

  // stage 1: horizontal interpolation of both rows
  always_comb begin
    dx_lo   = $signed({1'b0, texel_10}) - $signed({1'b0, texel_00});
    dx_hi   = $signed({1'b0, texel_11}) - $signed({1'b0, texel_01});
    px_lo   = $signed({{17{dx_lo[8]}}, dx_lo}) * $signed({10'b0, frac_x});
    px_hi   = $signed({{17{dx_hi[8]}}, dx_hi}) * $signed({10'b0, frac_x});
    lo_full = {3'b000, texel_00, 16'h0000} + {px_lo[25], px_lo};
    hi_full = {3'b000, texel_01, 16'h0000} + {px_hi[25], px_hi};
  end

  // stage 2: vertical product
  always_comb begin
    diff1     = $signed({1'b0, hi1}) - $signed({1'b0, lo1});
    prod_next = $signed({{17{diff1[24]}}, diff1}) * $signed({26'b0, fy1});
  end

  // stage 3: round, clamp, floor test, table access
  always_comb begin
    v_sum = $signed({2'b00, lo2}) + prod2[41:16] + 26'sh0008000;
    if (v_sum[25]) begin
      cov = 8'h00;
    end else if (v_sum[24]) begin
      cov = 8'hFF;
    end else begin
      cov = v_sum[23:16];
    end
    pass_next = (op2 == bcb_pkg::OP_PIXEL) && (edge2 != 8'h00) && (cov > coverage_floor);
    tab_we    = r3 && v2 && (op2 == bcb_pkg::OP_LOAD);
  end

  bcb_ram #(
    .WIDTH(bcb_pkg::ALPHA_W),
    .DEPTH(bcb_pkg::TABLE_DEPTH)
  ) u_alpha_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(idx2),
    .wdata(val2),
    .re   (r3),
    .raddr(cov),
    .rdata(tab_rdata)
  );

  // stage 4: fade product
  always_comb begin
    atab_next = hit3 ? tab_rdata : 8'h00;
    mul_next  = {8'h00, atab_next} * {8'h00, edge3} + 16'd127;
  end

  // stage 5: divide by 255
  always_comb begin
    div_sum    = mul4 + 16'd1 + {8'h00, mul4[15:8]};
    alpha_next = (edge4 == 8'hFF) ? atab4 : div_sum[15:8];
  end

  // stage 6: blend
  always_comb begin
    bg_std    = {bg5[7:0], bg5[15:8]};
    inv       = 8'hFF - alpha5;
    fg_rb     = {fg_color[15:11], 11'h000, fg_color[4:0]};
    bg_rb     = {bg_std[15:11], 11'h000, bg_std[4:0]};
    fg_g      = {fg_color[10:5], 5'h00};
    bg_g      = {bg_std[10:5], 5'h00};
    sum_rb    = {9'h000, fg_rb} * {22'h000000, alpha5}
              + {9'h000, bg_rb} * {22'h000000, inv};
    sum_g     = {9'h000, fg_g} * {12'h000, alpha5}
              + {9'h000, bg_g} * {12'h000, inv};
    blend_std = (alpha5 == 8'hFF) ? fg_color
              : {sum_rb[28:24], sum_g[18:13], sum_rb[12:8]};
    pixel_next = we5 ? {blend_std[7:0], blend_std[15:8]} : bg5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
      tab_valid <= '0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        v4 <= v3;
      end
      if (r5) begin
        v5 <= v4;
      end
      if (r6) begin
        out_valid <= v5;
      end
      if (tab_we) begin
        tab_valid[idx2] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      op1   <= op;
      idx1  <= lut_index;
      val1  <= lut_value;
      edge1 <= edge_alpha;
      fy1   <= frac_y;
      bg1   <= bg_pixel;
      lo1   <= lo_full[23:0];
      hi1   <= hi_full[23:0];
    end
    if (r2) begin
      op2   <= op1;
      idx2  <= idx1;
      val2  <= val1;
      edge2 <= edge1;
      bg2   <= bg1;
      lo2   <= lo1;
      prod2 <= prod_next;
    end
    if (r3) begin
      pass3 <= pass_next;
      hit3  <= tab_valid[cov];
      edge3 <= edge2;
      bg3   <= bg2;
    end
    if (r4) begin
      pass4 <= pass3;
      atab4 <= atab_next;
      edge4 <= edge3;
      bg4   <= bg3;
      mul4  <= mul_next;
    end
    if (r5) begin
      we5    <= pass4 && (alpha_next != 8'h00);
      alpha5 <= alpha_next;
      bg5    <= bg4;
    end
    if (r6) begin
      pixel_out    <= pixel_next;
      write_enable <= we5;
    end
  end

endmodule

// ----- rtl/bcb_checker.sv -----
// ----------------------------------------------------------------------------
// bcb_checker
// Port-level checks for the bilinear coverage blend block.
// ----------------------------------------------------------------------------
module bcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] pixel_out,
  input logic        write_enable
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(write_enable))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("item lost in pipeline");

endmodule

bind bilinear_coverage_blend_rgb565 bcb_checker u_bcb_checker (.*);
